// ===== design/pru_pkg.sv =====
package pru_pkg;

  localparam int FRAMES_DEF          = 16;
  localparam int PAGE_INDEX_BITS_DEF = 10;
  localparam int TIME_BITS_DEF       = 32;

  localparam int ADDR_BITS  = 32;
  localparam int COUNT_BITS = 32;
  localparam int LFSR_BITS  = 16;
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_SHIFT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAMES     = 2'd2;

  localparam logic [1:0] POL_SECOND_CHANCE = 2'd0;
  localparam logic [1:0] POL_LRU           = 2'd1;
  localparam logic [1:0] POL_FIFO          = 2'd2;
  localparam logic [1:0] POL_RANDOM        = 2'd3;

  localparam logic [1:0] POLICY_RESET     = POL_SECOND_CHANCE;
  localparam logic [4:0] PAGE_SHIFT_RESET = 5'd12;
  localparam logic [4:0] FRAMES_RESET     = 5'd16;

endpackage

// ===== design/pru_acc_if.sv =====
interface pru_acc_if;
  logic                           valid;
  logic                           ready;
  logic [pru_pkg::ADDR_BITS-1:0]  addr;
  logic                           is_write;

  modport source (output valid, addr, is_write, input ready);
  modport sink   (input valid, addr, is_write, output ready);
endinterface

// ===== design/pru_res_if.sv =====
interface pru_res_if #(
  parameter int FRAME_BITS = 4,
  parameter int PAGE_BITS  = 10
);
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [FRAME_BITS-1:0]           frame;
  logic                            evicted;
  logic [PAGE_BITS-1:0]            evicted_page;
  logic                            evicted_dirty;
  logic [pru_pkg::COUNT_BITS-1:0]  fault_count;

  modport source (output valid, hit, frame, evicted, evicted_page, evicted_dirty,
                  fault_count, input ready);
  modport sink   (input valid, hit, frame, evicted, evicted_page, evicted_dirty,
                  fault_count, output ready);
endinterface

// ===== design/pru_cfg_if.sv =====
interface pru_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pru_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [pru_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pru_ptab.sv =====
// Page table: one entry per page, {valid, frame}. Swept clear after reset.
module pru_ptab #(
  parameter int PAGE_INDEX_BITS = pru_pkg::PAGE_INDEX_BITS_DEF,
  parameter int FRAME_BITS      = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       clearing,
  input  logic                       rd_en,
  input  logic [PAGE_INDEX_BITS-1:0] rd_addr,
  output logic [FRAME_BITS:0]        rd_data,
  input  logic                       wr_en,
  input  logic [PAGE_INDEX_BITS-1:0] wr_addr,
  input  logic [FRAME_BITS:0]        wr_data
);

  localparam int PAGES = 1 << PAGE_INDEX_BITS;

  logic [FRAME_BITS:0]      mem [PAGES];
  logic [PAGE_INDEX_BITS:0] clr_cnt;

  assign clearing = !clr_cnt[PAGE_INDEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[PAGE_INDEX_BITS-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/page_replacement_unit.sv =====
// A hit goes straight to the result; a miss first scans for a free frame.
// Full miss: FIFO/LRU and second chance scan the frames, random picks one;
// one item at a time through a single scan index.
// One result per item; the next item is taken once the result is registered.
// Reset: synchronous; the page table is then swept clear, all
// 2**PAGE_INDEX_BITS entries (1024 by default), during which no item is taken.
module page_replacement_unit #(
  parameter int FRAMES          = pru_pkg::FRAMES_DEF,
  parameter int PAGE_INDEX_BITS = pru_pkg::PAGE_INDEX_BITS_DEF,
  parameter int TIME_BITS       = pru_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pru_acc_if.sink    acc,
  pru_res_if.source  res,
  pru_cfg_if.sink    cfg
);

  localparam int FB = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int LB = pru_pkg::LFSR_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;
  localparam logic [3:0] S_MIN   = 4'd3;
  localparam logic [3:0] S_SC    = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_EVICT = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state;

  // configuration
  logic [1:0] policy;
  logic [4:0] page_shift;
  logic [4:0] frames_in_use;

  // frame table
  logic [FRAMES-1:0]          used;
  logic [FRAMES-1:0]          dirty;
  logic [FRAMES-1:0]          refb;
  logic [PAGE_INDEX_BITS-1:0] fpage  [FRAMES];
  logic [TIME_BITS-1:0]       load_t [FRAMES];
  logic [TIME_BITS-1:0]       acc_t  [FRAMES];

  logic [CW-1:0]                   filled;
  logic [TIME_BITS-1:0]            clk_t;
  logic [pru_pkg::COUNT_BITS-1:0]  faults;
  logic [LB-1:0]                   lfsr;

  // per-item working registers
  logic [PAGE_INDEX_BITS-1:0] page_q;
  logic                       wr_q;
  logic                       hit_q;
  logic [CW-1:0]              n_q;
  logic [FB-1:0]              idx;
  logic [FB-1:0]              victim;
  logic [TIME_BITS-1:0]       best;
  logic [CW-1:0]              rem;
  logic [$clog2(LB)-1:0]      bit_cnt;

  logic                       clearing;
  logic                       accept;
  logic [PAGE_INDEX_BITS-1:0] page_calc;
  logic [FB:0]                rd_data;
  logic                       wr_en;
  logic [PAGE_INDEX_BITS-1:0] wr_addr;
  logic [FB:0]                wr_data;
  logic [CW-1:0]              n_calc;
  logic                       last;
  logic [TIME_BITS-1:0]       t_cur;
  logic                       t_less;
  logic [CW:0]                rem_sh;
  logic                       out_free;
  logic [LB-1:0]              lfsr_next;

  assign cfg.ready = 1'b1;
  assign acc.ready = (state == S_IDLE) && !clearing;
  assign accept    = acc.valid && acc.ready;
  assign out_free  = !res.valid || res.ready;

  logic [pru_pkg::ADDR_BITS-1:0] addr_sh;
  assign addr_sh   = acc.addr >> page_shift;
  assign page_calc = addr_sh[PAGE_INDEX_BITS-1:0];

  always_comb begin
    if (frames_in_use == 5'd0) begin
      n_calc = CW'(1);
    end else if (7'(frames_in_use) > 7'(FRAMES)) begin
      n_calc = CW'(FRAMES);
    end else begin
      n_calc = CW'(frames_in_use);
    end
  end

  assign last   = (CW'(idx) + CW'(1)) == n_q;
  assign t_cur  = (state == S_MIN && policy == pru_pkg::POL_LRU) ? acc_t[idx] : load_t[idx];
  assign t_less = t_cur < best;
  assign rem_sh = {rem, lfsr[bit_cnt]};
  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ pru_pkg::LFSR_TAPS) : (lfsr >> 1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = page_q;
    wr_data = {1'b1, idx};
    if (state == S_EVICT && used[idx]) begin
      wr_en   = 1'b1;
      wr_addr = fpage[idx];
      wr_data = '0;
    end else if (state == S_FIN && out_free && !hit_q) begin
      wr_en = 1'b1;
    end
  end

  pru_ptab #(
    .PAGE_INDEX_BITS(PAGE_INDEX_BITS),
    .FRAME_BITS     (FB)
  ) u_ptab (
    .clk     (clk),
    .rst     (rst),
    .clearing(clearing),
    .rd_en   (accept),
    .rd_addr (page_calc),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= pru_pkg::POLICY_RESET;
      page_shift    <= pru_pkg::PAGE_SHIFT_RESET;
      frames_in_use <= pru_pkg::FRAMES_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pru_pkg::REG_POLICY:     policy        <= cfg.data[1:0];
        pru_pkg::REG_PAGE_SHIFT: page_shift    <= cfg.data;
        pru_pkg::REG_FRAMES:     frames_in_use <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      dirty     <= '0;
      refb      <= '0;
      filled    <= '0;
      clk_t     <= '0;
      faults    <= '0;
      lfsr      <= LB'(1);
      res.valid <= 1'b0;
    end else begin
      // in S_FIN a taken result is replaced by the new one below
      if (res.valid && res.ready && state != S_FIN) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            page_q <= page_calc;
            wr_q   <= acc.is_write;
            n_q    <= n_calc;
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_q <= rd_data[FB];
          if (rd_data[FB]) begin
            idx   <= rd_data[FB-1:0];
            state <= S_FIN;
          end else begin
            faults <= faults + 1'b1;
            idx    <= '0;
            state  <= S_FREE;
          end
        end
        S_FREE: begin
          if (!used[idx]) begin
            state <= S_FIN;
          end else if (last) begin
            idx    <= '0;
            victim <= '0;
            best   <= '1;
            unique case (policy)
              pru_pkg::POL_SECOND_CHANCE: state <= S_SC;
              pru_pkg::POL_LRU, pru_pkg::POL_FIFO: state <= S_MIN;
              default: begin
                lfsr    <= lfsr_next;
                rem     <= '0;
                bit_cnt <= '1;
                state   <= S_MOD;
              end
            endcase
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MIN: begin
          if (t_less) begin
            best   <= t_cur;
            victim <= idx;
          end
          if (last) begin
            idx   <= t_less ? idx : victim;
            state <= S_EVICT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SC: begin
          if (t_less && refb[idx]) begin
            // referenced older page: second chance, rescan from frame 0
            refb[idx]   <= 1'b0;
            load_t[idx] <= clk_t;
            idx         <= '0;
          end else begin
            if (t_less) begin
              best   <= t_cur;
              victim <= idx;
            end
            if (last) begin
              idx   <= t_less ? idx : victim;
              state <= S_EVICT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_MOD: begin
          // restoring remainder, one lfsr bit per cycle
          if (rem_sh >= {1'b0, n_q}) begin
            rem <= CW'(rem_sh - {1'b0, n_q});
          end else begin
            rem <= CW'(rem_sh);
          end
          if (bit_cnt == '0) begin
            idx   <= (rem_sh >= {1'b0, n_q}) ? FB'(rem_sh - {1'b0, n_q}) : FB'(rem_sh);
            state <= S_EVICT;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_EVICT: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            res.valid         <= 1'b1;
            res.hit           <= hit_q;
            res.frame         <= idx;
            res.evicted       <= !hit_q && used[idx];
            res.evicted_page  <= (!hit_q && used[idx]) ? fpage[idx] : '0;
            res.evicted_dirty <= !hit_q && used[idx] && dirty[idx];
            res.fault_count   <= faults;
            if (hit_q) begin
              refb[idx]  <= 1'b1;
              acc_t[idx] <= clk_t;
              if (wr_q) begin
                dirty[idx] <= 1'b1;
              end
            end else begin
              if (!used[idx]) begin
                filled <= filled + 1'b1;
              end
              fpage[idx]  <= page_q;
              used[idx]   <= 1'b1;
              dirty[idx]  <= wr_q;
              refb[idx]   <= 1'b0;
              load_t[idx] <= clk_t;
              acc_t[idx]  <= clk_t;
            end
            clk_t <= clk_t + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOK)
    else $error("accepted item did not start lookup");

  a_filled_max: assert property (@(posedge clk) disable iff (rst)
    filled <= CW'(FRAMES))
    else $error("frame fill count beyond frame count");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == S_FIN)
    else $error("result raised outside final step");

  a_fault_on_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && !rd_data[FB]) |=> faults == $past(faults) + 1'b1)
    else $error("miss did not count a fault");

endmodule
